FILE: src/ptfs_pkg.sv
// ----------------------------------------------------------------------------
// ptfs_pkg: shared types and codes of the periodic task flag scheduler
// Field widths, the item kind codes and the layout of one slot memory entry.
// ----------------------------------------------------------------------------
package ptfs_pkg;

	// Fixed field widths.
	localparam int ID_W   = 5;
	localparam int FREQ_W = 20;
	localparam int MASK_W = 32;

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [ID_W:0]     id_ext_t;
	typedef logic [FREQ_W-1:0] freq_t;
	typedef logic [MASK_W-1:0] mask_t;

	// Item kind codes.
	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_ENABLE  = 2'd1,
		KIND_DISABLE = 2'd2,
		KIND_EXEC    = 2'd3
	} kind_t;

	// Reset value of the tick rate register, in hertz.
	localparam freq_t TICK_RATE_RESET = freq_t'(1000);

	// One entry of the slot memory: tick counter and period.
	typedef struct packed {
		freq_t count;
		freq_t period;
	} slot_t;

endpackage

FILE: src/ptfs_div.sv
// ----------------------------------------------------------------------------
// ptfs_div: restoring divider for the task period
// Works out dividend / divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ptfs_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  ptfs_pkg::freq_t       dividend,
	input  ptfs_pkg::freq_t       divisor,
	output logic                  done,
	output ptfs_pkg::freq_t       quotient
);

	localparam int STEPS = ptfs_pkg::FREQ_W;

	logic                      busy_q;
	logic                      done_q;
	logic [4:0]                step_q;
	ptfs_pkg::freq_t           rem_q;
	ptfs_pkg::freq_t           quo_q;
	ptfs_pkg::freq_t           div_q;
	logic [STEPS:0]            shifted;
	logic [STEPS+1:0]          diff;
	logic                      borrow;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		shifted = {rem_q, quo_q[STEPS-1]};
		diff    = {1'b0, shifted} - {2'b00, div_q};
		borrow  = diff[STEPS+1];
	end

	// Iteration control; the dividend is shifted out of the quotient register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= borrow ? shifted[STEPS-1:0] : diff[STEPS-1:0];
			quo_q <= {quo_q[STEPS-2:0], ~borrow};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: src/ptfs_slot_ram.sv
// ----------------------------------------------------------------------------
// ptfs_slot_ram: slot memory holding each task's counter and period
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ptfs_slot_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  ptfs_pkg::slot_t   wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output ptfs_pkg::slot_t   rdata
);

	ptfs_pkg::slot_t mem [DEPTH];
	ptfs_pkg::slot_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, read data registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/periodic_task_flag_scheduler_core.sv
// ----------------------------------------------------------------------------
// periodic_task_flag_scheduler_core: periodic task flag scheduler
// Up to NUM_TASKS slots with an enable bit, a tick counter, a period and a
// pending flag; counters and periods live in a single slot memory.
// ----------------------------------------------------------------------------
// The block takes one word at a time. A tick word walks every slot through
// the memory, one read a cycle with a write-back for each enabled slot. An
// enable word runs the period division one quotient bit a cycle; a rejected
// enable and a disable go straight to their result. An execute word scans
// the pending flags one slot a cycle, holding on a pending slot while the
// output is stalled, and gives one result per pending task, or a single
// empty one when none is pending. The slot memory needs no clearing pass:
// an enable always rewrites both counter and period before a slot is ticked.
// Configuration writes are always taken.
module periodic_task_flag_scheduler_core #(
	parameter int NUM_TASKS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration channel: tick rate.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [19:0] cfg_data,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [4:0]  task_id,
	input  logic [19:0] frequency,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  task_number,
	output logic        task_valid,
	output logic        accepted,
	output logic [31:0] pending_mask,
	output logic        last
);

	localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CNT_W = $clog2(NUM_TASKS + 1);
	localparam ptfs_pkg::id_ext_t TASKS_LIM = ptfs_pkg::id_ext_t'(NUM_TASKS);
	localparam ptfs_pkg::mask_t SLOT_MASK =
		ptfs_pkg::mask_t'((64'd1 << NUM_TASKS) - 64'd1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_DIV,
		ST_EXEC,
		ST_RESULT
	} state_t;

	state_t              state_q;
	ptfs_pkg::freq_t     rate_q;
	ptfs_pkg::mask_t     enable_q;
	ptfs_pkg::mask_t     pending_q;
	ptfs_pkg::mask_t     snap_q;
	ptfs_pkg::id_t       id_q;
	logic                acc_q;
	logic [CNT_W-1:0]    issue_q;
	ptfs_pkg::id_t       exec_idx_q;
	logic                tick_v_s1;
	logic [IDX_W-1:0]    tick_idx_s1;

	logic                out_valid_q;
	ptfs_pkg::id_t       task_number_q;
	logic                task_valid_q;
	logic                accepted_q;
	ptfs_pkg::mask_t     pending_mask_q;
	logic                last_q;

	logic                in_take;
	logic                id_ok;
	logic                enable_ok;
	logic                out_free;
	logic                out_load;
	logic                issuing;
	logic                div_start;
	logic                div_done;
	ptfs_pkg::freq_t     div_quo;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	ptfs_pkg::slot_t     mem_wdata;
	ptfs_pkg::slot_t     mem_rdata;
	logic [ptfs_pkg::FREQ_W:0] tick_sum;
	logic                tick_wrap;
	logic                tick_en;
	ptfs_pkg::mask_t     tick_bit;
	ptfs_pkg::mask_t     exec_rest;

	// Handshake and decode of the incoming word.
	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign id_ok     = {1'b0, task_id} < TASKS_LIM;
	assign enable_ok = id_ok && (frequency != '0) && (frequency <= rate_q);
	assign div_start = in_take && (kind == ptfs_pkg::KIND_ENABLE) && enable_ok;
	assign out_free  = !out_valid_q || !out_stall;
	assign issuing   = (state_q == ST_TICK) && (issue_q < CNT_W'(NUM_TASKS));

	// The output register takes a new word in this cycle.
	assign out_load  = out_free && ((state_q == ST_RESULT) ||
		(state_q == ST_EXEC && (snap_q == '0 || snap_q[exec_idx_q])));

	// Tick update of the slot returned by the memory.
	always_comb begin
		tick_sum  = {1'b0, mem_rdata.count} + 21'd1;
		tick_wrap = tick_sum >= {1'b0, mem_rdata.period};
		tick_en   = enable_q[ptfs_pkg::id_t'(tick_idx_s1)];
		tick_bit  = ptfs_pkg::mask_t'(1) << tick_idx_s1;
		exec_rest = snap_q & ~(ptfs_pkg::mask_t'(1) << exec_idx_q);
	end

	// Memory write port: tick write-back or a fresh slot after an enable.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tick_idx_s1;
		mem_wdata = '{count: '0, period: '0};
		if (state_q == ST_TICK && tick_v_s1 && tick_en) begin
			mem_we          = 1'b1;
			mem_wdata.count = tick_wrap ? tick_sum[ptfs_pkg::FREQ_W-1:0] -
				mem_rdata.period : tick_sum[ptfs_pkg::FREQ_W-1:0];
			mem_wdata.period = mem_rdata.period;
		end else if (state_q == ST_DIV && div_done) begin
			mem_we           = 1'b1;
			mem_waddr        = id_q[IDX_W-1:0];
			mem_wdata.period = div_quo;
		end
	end

	ptfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rate_q),
		.divisor  (frequency),
		.done     (div_done),
		.quotient (div_quo)
	);

	ptfs_slot_ram #(
		.DEPTH (NUM_TASKS),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (issuing),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	// Sequencer, flag registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rate_q      <= ptfs_pkg::TICK_RATE_RESET;
			enable_q    <= '0;
			pending_q   <= '0;
			tick_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				rate_q <= cfg_data;
			end
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						id_q   <= task_id;
						acc_q  <= 1'b0;
						case (ptfs_pkg::kind_t'(kind))
							ptfs_pkg::KIND_TICK: begin
								issue_q   <= '0;
								tick_v_s1 <= 1'b0;
								state_q   <= ST_TICK;
							end
							ptfs_pkg::KIND_ENABLE: begin
								state_q <= enable_ok ? ST_DIV : ST_RESULT;
							end
							ptfs_pkg::KIND_DISABLE: begin
								if (id_ok) begin
									enable_q  <= enable_q &
										~(ptfs_pkg::mask_t'(1) << task_id);
									pending_q <= pending_q &
										~(ptfs_pkg::mask_t'(1) << task_id);
								end
								state_q <= ST_RESULT;
							end
							ptfs_pkg::KIND_EXEC: begin
								snap_q     <= pending_q & SLOT_MASK;
								pending_q  <= '0;
								exec_idx_q <= '0;
								state_q    <= ST_EXEC;
							end
							default: state_q <= ST_RESULT;
						endcase
					end
				end
				ST_TICK: begin
					// Read slot i while slot i-1 is written back.
					tick_v_s1   <= issuing;
					tick_idx_s1 <= issue_q[IDX_W-1:0];
					if (issuing) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (tick_v_s1 && tick_en && tick_wrap) begin
						pending_q <= pending_q | tick_bit;
					end
					if (!issuing && !tick_v_s1) begin
						state_q <= ST_RESULT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						enable_q <= enable_q | (ptfs_pkg::mask_t'(1) << id_q);
						acc_q    <= 1'b1;
						state_q  <= ST_RESULT;
					end
				end
				ST_EXEC: begin
					// One slot a cycle unless a pending one waits on a stalled output; a result for each pending one.
					if (snap_q == '0) begin
						if (out_free) begin
							out_valid_q    <= 1'b1;
							task_number_q  <= '0;
							task_valid_q   <= 1'b0;
							accepted_q     <= 1'b0;
							pending_mask_q <= '0;
							last_q         <= 1'b1;
							state_q        <= ST_IDLE;
						end
					end else if (snap_q[exec_idx_q]) begin
						if (out_free) begin
							out_valid_q    <= 1'b1;
							task_number_q  <= exec_idx_q;
							task_valid_q   <= 1'b1;
							accepted_q     <= 1'b0;
							pending_mask_q <= '0;
							last_q         <= (exec_rest == '0);
							snap_q         <= exec_rest;
							exec_idx_q     <= exec_idx_q + 5'd1;
							if (exec_rest == '0) begin
								state_q <= ST_IDLE;
							end
						end
					end else begin
						exec_idx_q <= exec_idx_q + 5'd1;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						task_number_q  <= '0;
						task_valid_q   <= 1'b0;
						accepted_q     <= acc_q;
						pending_mask_q <= pending_q;
						last_q         <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign task_number  = task_number_q;
	assign task_valid   = task_valid_q;
	assign accepted     = accepted_q;
	assign pending_mask = pending_mask_q;
	assign last         = last_q;

	// The slot memory is only written while ticking or finishing an enable.
	a_mem_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_TICK || state_q == ST_DIV))
		else $error("slot memory written outside tick or enable");

	// Slots beyond the configured count never become pending.
	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q & ~SLOT_MASK) == '0)
		else $error("pending flag set for a slot that does not exist");

	// An execute word clears every pending flag at once.
	a_exec_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && kind == ptfs_pkg::KIND_EXEC) |=> (pending_q == '0))
		else $error("pending flags not cleared by execute");

	// An enable result reports acceptance only after a division has finished.
	a_acc_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(acc_q) |-> $past(div_done))
		else $error("enable accepted without a finished division");

endmodule

FILE: verif/tb_periodic_task_flag_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_periodic_task_flag_scheduler_core: self-checking bench for the scheduler
// Drives tick, enable, disable and execute words with random gaps and output
// stalls, predicts every result word in a small scoreboard and compares each
// field. The tick rate register is set to zero, one, 1000000 and random values between phases.
// ----------------------------------------------------------------------------
module tb_periodic_task_flag_scheduler_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS        = 32;
	localparam int CYCLE_LIMIT  = 5000000;
	localparam int PHASE_WORDS  = 64;
	localparam int BURST_WORDS  = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_WAIT  = 8;
	localparam int TAIL_CYCLES  = 40;
	localparam int FREQ_MAX     = 1000000;

	// One result word as seen on the output channel.
	typedef struct {
		ptfs_pkg::id_t   number;
		logic            valid;
		logic            acc;
		ptfs_pkg::mask_t mask;
		logic            fin;
	} sched_result_t;

	// Scheduler predictor and queue of result words still due.
	class sched_scoreboard;
		ptfs_pkg::freq_t rate;
		ptfs_pkg::mask_t enabled;
		ptfs_pkg::mask_t pending;
		int unsigned     count [SLOTS];
		int unsigned     period [SLOTS];
		sched_result_t   due [$];
		int              failures;

		function new();
			rate     = ptfs_pkg::TICK_RATE_RESET;
			enabled  = '0;
			pending  = '0;
			failures = 0;
			foreach (count[i]) begin
				count[i]  = 0;
				period[i] = 0;
			end
		endfunction

		function void set_rate(ptfs_pkg::freq_t r);
			rate = r;
		endfunction

		// Apply one accepted input word and queue the result words it causes.
		function void note_item(ptfs_pkg::kind_t k, ptfs_pkg::id_t id,
			ptfs_pkg::freq_t f);
			sched_result_t   res;
			ptfs_pkg::mask_t snap;
			logic            acc;
			int unsigned     c;
			int              n;

			acc = 1'b0;
			res.number = '0;
			res.valid  = 1'b0;
			res.acc    = 1'b0;
			res.mask   = '0;
			res.fin    = 1'b1;
			case (k)
				ptfs_pkg::KIND_TICK: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (enabled[i]) begin
							c = count[i] + 1;
							if (c >= period[i]) begin
								c -= period[i];
								pending[i] = 1'b1;
							end
							count[i] = c;
						end
					end
				end
				ptfs_pkg::KIND_ENABLE: begin
					if (f != 0 && f <= rate) begin
						enabled[id] = 1'b1;
						count[id]   = 0;
						period[id]  = rate / f;
						acc         = 1'b1;
					end
				end
				ptfs_pkg::KIND_DISABLE: begin
					enabled[id] = 1'b0;
					pending[id] = 1'b0;
					count[id]   = 0;
				end
				default: begin
					// Execute: one word per pending task, ascending, all with mask zero.
					snap    = pending;
					pending = '0;
					n = 0;
					for (int i = 0; i < SLOTS; i++) begin
						if (snap[i]) begin
							res.number = ptfs_pkg::id_t'(i);
							res.valid  = 1'b1;
							res.fin    = 1'b0;
							due.push_back(res);
							n++;
						end
					end
					if (n == 0)
						due.push_back(res);
					else
						due[due.size() - 1].fin = 1'b1;
					return;
				end
			endcase
			res.acc  = acc;
			res.mask = pending;
			due.push_back(res);
		endfunction

		// Compare one accepted result word with the oldest one due.
		function void check_result(sched_result_t got);
			sched_result_t want;

			if (due.size() == 0) begin
				$error("unexpected result word: task_number %0d task_valid %0b",
					got.number, got.valid);
				failures++;
				return;
			end
			want = due.pop_front();
			if (got.number !== want.number) begin
				$error("task_number: expected %0d, got %0d", want.number, got.number);
				failures++;
			end
			if (got.valid !== want.valid) begin
				$error("task_valid: expected %0b, got %0b", want.valid, got.valid);
				failures++;
			end
			if (got.acc !== want.acc) begin
				$error("accepted: expected %0b, got %0b", want.acc, got.acc);
				failures++;
			end
			if (got.mask !== want.mask) begin
				$error("pending_mask: expected %h, got %h", want.mask, got.mask);
				failures++;
			end
			if (got.fin !== want.fin) begin
				$error("last: expected %0b, got %0b", want.fin, got.fin);
				failures++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [19:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [4:0]  task_id;
	logic [19:0] frequency;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  task_number;
	logic        task_valid;
	logic        accepted;
	logic [31:0] pending_mask;
	logic        last;

	sched_scoreboard sb;
	int unsigned     cycles;
	bit              quiet;
	bit              hold_go;
	int              hold_left;
	int              run_left;

	periodic_task_flag_scheduler_core #(
		.NUM_TASKS(SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.task_id      (task_id),
		.frequency    (frequency),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.task_number  (task_number),
		.task_valid   (task_valid),
		.accepted     (accepted),
		.pending_mask (pending_mask),
		.last         (last)
	);

	// Free-running 10 ns clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int unsigned r;

		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Output stall: random runs, a long hold on request, none when quiet.
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go   = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else if (run_left > 0) begin
			run_left--;
		end else begin
			out_stall <= ($urandom_range(0, 2) == 0);
			run_left = pick_gap();
		end
	end

	// Watch both channels at every edge; words are taken from pre-edge values.
	always @(posedge clk) begin
		sched_result_t got;

		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && in_valid && !in_stall)
			sb.note_item(ptfs_pkg::kind_t'(kind), task_id, frequency);
		if (arst_n && out_valid && !out_stall) begin
			got.number = task_number;
			got.valid  = task_valid;
			got.acc    = accepted;
			got.mask   = pending_mask;
			got.fin    = last;
			sb.check_result(got);
		end
	end

	// Offer one input word after a random gap and return once it is taken.
	task automatic send_item(ptfs_pkg::kind_t k, ptfs_pkg::id_t id,
		ptfs_pkg::freq_t f);
		int gap;

		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		task_id   <= id;
		frequency <= f;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop offering and wait until every result word due has come out.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	// Write the tick rate register; the block must be idle.
	task automatic write_rate(ptfs_pkg::freq_t r);
		cfg_valid <= 1'b1;
		cfg_data  <= r;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_rate(r);
	endtask

	// Frequency biased towards short periods, with rejected cases mixed in.
	function automatic ptfs_pkg::freq_t pick_frequency(ptfs_pkg::freq_t rate);
		int unsigned r;
		int unsigned f;

		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 18 && rate < FREQ_MAX)
			return ptfs_pkg::freq_t'($urandom_range(int'(rate) + 1, FREQ_MAX));
		if (r < 30 || rate == 0)
			return ptfs_pkg::freq_t'($urandom_range(0, FREQ_MAX));
		f = rate / $urandom_range(1, 8);
		return ptfs_pkg::freq_t'((f == 0) ? 1 : f);
	endfunction

	// One random word, weighted towards ticks so that tasks come due.
	task automatic random_item();
		int unsigned     r;
		ptfs_pkg::kind_t k;

		r = $urandom_range(0, 99);
		if (r < 45)
			k = ptfs_pkg::KIND_TICK;
		else if (r < 70)
			k = ptfs_pkg::KIND_ENABLE;
		else if (r < 80)
			k = ptfs_pkg::KIND_DISABLE;
		else
			k = ptfs_pkg::KIND_EXEC;
		send_item(k, ptfs_pkg::id_t'($urandom_range(0, SLOTS - 1)),
			pick_frequency(sb.rate));
	endtask

	// Main sequence: reset, directed words, then random phases per tick rate.
	initial begin
		ptfs_pkg::freq_t rates [5];

		sb        = new();
		cycles    = 0;
		quiet     = 1'b0;
		hold_go   = 1'b0;
		hold_left = 0;
		run_left  = 0;
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		kind      <= ptfs_pkg::KIND_TICK;
		task_id   <= '0;
		frequency <= '0;
		out_stall <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset tick rate of 1000 Hz.
		send_item(ptfs_pkg::KIND_EXEC, 5'd0, 20'd0);
		send_item(ptfs_pkg::KIND_ENABLE, 5'd0, 20'd0);
		send_item(ptfs_pkg::KIND_ENABLE, 5'd1, 20'd1001);
		send_item(ptfs_pkg::KIND_ENABLE, 5'd2, ptfs_pkg::freq_t'(FREQ_MAX));
		send_item(ptfs_pkg::KIND_ENABLE, 5'd0, 20'd1000);
		send_item(ptfs_pkg::KIND_ENABLE, 5'd31, 20'd1);
		send_item(ptfs_pkg::KIND_ENABLE, 5'd5, 20'd500);
		send_item(ptfs_pkg::KIND_ENABLE, 5'd12, 20'd333);
		send_item(ptfs_pkg::KIND_TICK, 5'd0, 20'd0);
		send_item(ptfs_pkg::KIND_TICK, 5'd31, 20'hFFFFF);
		send_item(ptfs_pkg::KIND_TICK, 5'd0, 20'd0);
		send_item(ptfs_pkg::KIND_EXEC, 5'd0, 20'd0);
		send_item(ptfs_pkg::KIND_TICK, 5'd0, 20'd0);
		send_item(ptfs_pkg::KIND_TICK, 5'd0, 20'd0);
		// Re-enabling a pending task keeps its flag; a disable drops it.
		send_item(ptfs_pkg::KIND_ENABLE, 5'd0, 20'd250);
		send_item(ptfs_pkg::KIND_DISABLE, 5'd5, 20'd0);
		send_item(ptfs_pkg::KIND_EXEC, 5'd0, 20'd0);
		send_item(ptfs_pkg::KIND_DISABLE, 5'd17, 20'd0);
		send_item(ptfs_pkg::KIND_EXEC, 5'd0, 20'd0);
		send_item(ptfs_pkg::KIND_ENABLE, 5'd31, 20'd999);
		send_item(ptfs_pkg::KIND_TICK, 5'd0, 20'd0);
		send_item(ptfs_pkg::KIND_DISABLE, 5'd31, 20'd0);
		settle();

		// With a tick rate of zero every enable is turned down.
		write_rate('0);
		send_item(ptfs_pkg::KIND_ENABLE, 5'd3, 20'd1);
		send_item(ptfs_pkg::KIND_TICK, 5'd0, 20'd0);
		send_item(ptfs_pkg::KIND_EXEC, 5'd0, 20'd0);
		settle();

		rates[0] = ptfs_pkg::TICK_RATE_RESET;
		rates[1] = ptfs_pkg::freq_t'(1);
		rates[2] = ptfs_pkg::freq_t'(FREQ_MAX);
		rates[3] = ptfs_pkg::freq_t'($urandom_range(2, 50));
		rates[4] = ptfs_pkg::freq_t'($urandom_range(51, FREQ_MAX));

		for (int p = 0; p < 5; p++) begin
			write_rate(rates[p]);
			quiet = (p == 2);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				random_item();
				// Hold the output off while words keep coming, so the block backs up.
				if (p == 3 && n == 10) begin
					quiet   = 1'b1;
					hold_go = 1'b1;
					for (int b = 0; b < BURST_WORDS; b++)
						random_item();
					quiet = 1'b0;
				end
			end
			settle();
		end

		quiet = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
src/ptfs_pkg.sv
src/ptfs_div.sv
src/ptfs_slot_ram.sv
src/periodic_task_flag_scheduler_core.sv
verif/tb_periodic_task_flag_scheduler_core.sv
